### rtl/core/ethp_pkg.sv
// Shared types and constants for the Ethernet/IPv4/TCP header parser.
// No dependencies; imported by every module of the core.
package ethp_pkg;

    localparam int unsigned C_TDATA_IN_W  = 8;
    localparam int unsigned C_TDATA_OUT_W = 240;
    localparam int unsigned C_LIMIT_W     = 5;

    localparam logic [15:0]          C_ETYPE_IPV4  = 16'h0800;
    localparam logic [7:0]           C_PROTO_TCP   = 8'd6;
    localparam logic [C_LIMIT_W-1:0] C_PREVIEW_MAX = 5'd16;

    // Result kinds carried on tuser
    localparam logic C_KIND_PREVIEW = 1'b0;
    localparam logic C_KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         payload_byte;
        logic [47:0]        dest_mac;
        logic [47:0]        source_mac;
        logic [31:0]        source_ip;
        logic [31:0]        dest_ip;
        logic [15:0]        src_port;
        logic [15:0]        dst_port;
        logic [15:0]        captured_bytes;
        logic signed [16:0] payload_length;
        logic               is_ipv4_tcp;
        logic               frame_done;
    } t_ethp_result;

    // Up to two results per accepted byte; b is only set when a is set
    typedef struct packed {
        logic         a_valid;
        logic         b_valid;
        t_ethp_result a;
        t_ethp_result b;
    } t_ethp_push;

endpackage

### rtl/core/eth_ipv4_tcp_header_parser_core.sv
// Ethernet/IPv4/TCP header parser core: top level.
// Results pass through the result queue (P_FIFO_DEPTH entries) to the master side.
// Throughput: one frame byte per cycle while the queue has room; a previewed last byte
// yields two results, drained one per cycle by the queue while m_axis_tready is high.
// Reset: synchronous, active low; clears frame state and queue, preview limit to 16.
// Depends on ethp_pkg, ethp_capture and ethp_fifo.
module eth_ipv4_tcp_header_parser_core #(
    parameter int unsigned P_FIFO_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: preview limit
    input  logic                               i_cfg_we,
    input  logic [ethp_pkg::C_LIMIT_W-1:0]     i_cfg_wdata,
    // byte stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ethp_pkg::C_TDATA_IN_W-1:0]  s_axis_tdata,  // [7:0] frame_byte
    input  logic                               s_axis_tlast,  // frame_end
    // results out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] payload_byte, [55:8] dest_mac, [103:56] source_mac,
    // [135:104] source_ip, [167:136] dest_ip, [183:168] src_port,
    // [199:184] dst_port, [215:200] captured_bytes,
    // [232:216] payload_length, [233] is_ipv4_tcp, [239:234] zero
    output logic [ethp_pkg::C_TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                               m_axis_tuser,  // result_kind
    output logic                               m_axis_tlast   // frame_done
);
    import ethp_pkg::*;

    logic         accept;
    logic         room;
    t_ethp_push   push;
    t_ethp_result res;

    // Take a byte whenever the queue can absorb the worst case of two results,
    // so the parser never waits on a result that is still being offered.
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ethp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_push      (push)
    );

    ethp_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res)
    );

    // Pack the result fields, lowest field first, zero pad to whole bytes
    assign m_axis_tdata = {6'd0,
                           res.is_ipv4_tcp,
                           res.payload_length,
                           res.captured_bytes,
                           res.dst_port,
                           res.src_port,
                           res.dest_ip,
                           res.source_ip,
                           res.source_mac,
                           res.dest_mac,
                           res.payload_byte};
    assign m_axis_tuser = res.result_kind;
    assign m_axis_tlast = res.frame_done;

    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == C_KIND_SUMMARY)))
        else $error("frame_done disagrees with result kind");

    a_preview_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == C_KIND_PREVIEW) |-> (m_axis_tdata[239:8] == '0))
        else $error("preview result carries header fields");

    a_stall_in_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && !s_axis_tready) |=> !($past(accept)))
        else $error("byte accepted with no queue room");

endmodule

### rtl/core/ethp_capture.sv
// Byte offset tracking, header field capture and preview decision.
// Depends on ethp_pkg.
module ethp_capture (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ethp_pkg::C_LIMIT_W-1:0] i_cfg_wdata,
    input  logic                           i_accept,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    output ethp_pkg::t_ethp_push           o_push
);
    import ethp_pkg::*;

    localparam logic [15:0] C_OFS_SMAC   = 16'd6;
    localparam logic [15:0] C_OFS_ETYPE  = 16'd12;
    localparam logic [15:0] C_OFS_IHL    = 16'd14;
    localparam logic [15:0] C_OFS_TLEN0  = 16'd16;
    localparam logic [15:0] C_OFS_TLEN1  = 16'd17;
    localparam logic [15:0] C_OFS_PROTO  = 16'd23;
    localparam logic [15:0] C_OFS_SIP    = 16'd26;
    localparam logic [15:0] C_OFS_DIP    = 16'd30;
    localparam logic [15:0] C_OFS_IPEND  = 16'd34;
    localparam logic [15:0] C_TCP_DOFF   = 16'd12;
    localparam logic [15:0] C_INDEX_MAX  = 16'hFFFF;

    logic [C_LIMIT_W-1:0] r_limit;
    logic [15:0] r_index, n_index;
    logic [47:0] r_dmac, n_dmac, r_smac, n_smac;
    logic [15:0] r_etype, n_etype, r_tlen, n_tlen;
    logic [3:0]  r_ihl, n_ihl, r_toff, n_toff;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_sip, n_sip, r_dip, n_dip;
    logic [15:0] r_sport, n_sport, r_dport, n_dport;

    logic [15:0]          tcp_at, body_at, body_ofs;
    logic signed [16:0]   plen;
    logic [C_LIMIT_W-1:0] limit;
    logic                 hdr_match, preview;
    t_ethp_result         res_prev, res_sum;

    always_comb begin
        n_dmac  = r_dmac;
        n_smac  = r_smac;
        n_etype = r_etype;
        n_ihl   = r_ihl;
        n_tlen  = r_tlen;
        n_proto = r_proto;
        n_sip   = r_sip;
        n_dip   = r_dip;
        n_sport = r_sport;
        n_dport = r_dport;
        n_toff  = r_toff;

        // fixed-offset Ethernet and IP fields
        if (r_index < C_OFS_SMAC) begin
            n_dmac = {r_dmac[39:0], i_byte};
        end else if (r_index < C_OFS_ETYPE) begin
            n_smac = {r_smac[39:0], i_byte};
        end else if (r_index < C_OFS_IHL) begin
            n_etype = {r_etype[7:0], i_byte};
        end else if (r_index == C_OFS_IHL) begin
            n_ihl = i_byte[3:0];
        end else if (r_index == C_OFS_TLEN0 || r_index == C_OFS_TLEN1) begin
            n_tlen = {r_tlen[7:0], i_byte};
        end else if (r_index == C_OFS_PROTO) begin
            n_proto = i_byte;
        end else if (r_index >= C_OFS_SIP && r_index < C_OFS_DIP) begin
            n_sip = {r_sip[23:0], i_byte};
        end else if (r_index >= C_OFS_DIP && r_index < C_OFS_IPEND) begin
            n_dip = {r_dip[23:0], i_byte};
        end

        // TCP fields float with the IHL just seen
        tcp_at = C_OFS_IHL + {10'd0, n_ihl, 2'b00};
        if (r_index == tcp_at || r_index == tcp_at + 16'd1) begin
            n_sport = {r_sport[7:0], i_byte};
        end
        if (r_index == tcp_at + 16'd2 || r_index == tcp_at + 16'd3) begin
            n_dport = {r_dport[7:0], i_byte};
        end
        if (r_index == tcp_at + C_TCP_DOFF) begin
            n_toff = i_byte[7:4];
        end

        body_at   = tcp_at + {10'd0, n_toff, 2'b00};
        body_ofs  = r_index - body_at;
        plen      = $signed({1'b0, n_tlen}) - $signed({11'd0, n_ihl, 2'b00})
                  - $signed({11'd0, n_toff, 2'b00});
        limit     = (r_limit > C_PREVIEW_MAX) ? C_PREVIEW_MAX : r_limit;
        hdr_match = (n_etype == C_ETYPE_IPV4) && (n_proto == C_PROTO_TCP);

        preview = i_accept && hdr_match
               && (r_index >= C_OFS_PROTO)
               && (r_index >= tcp_at + C_TCP_DOFF)
               && (r_index >= body_at)
               && (plen > 17'sd0)
               && (body_ofs < {11'd0, limit})
               && ($signed({1'b0, body_ofs}) < plen);

        n_index = (r_index == C_INDEX_MAX) ? r_index : r_index + 16'd1;

        res_prev              = '0;
        res_prev.result_kind  = C_KIND_PREVIEW;
        res_prev.payload_byte = i_byte;

        res_sum                = '0;
        res_sum.result_kind    = C_KIND_SUMMARY;
        res_sum.dest_mac       = n_dmac;
        res_sum.source_mac     = n_smac;
        res_sum.source_ip      = n_sip;
        res_sum.dest_ip        = n_dip;
        res_sum.src_port       = n_sport;
        res_sum.dst_port       = n_dport;
        res_sum.captured_bytes = n_index;
        res_sum.payload_length = plen;
        res_sum.is_ipv4_tcp    = hdr_match;
        res_sum.frame_done     = 1'b1;

        // preview goes first when the last byte is also payload
        o_push         = '0;
        o_push.a_valid = preview || (i_accept && i_last);
        o_push.b_valid = preview && i_accept && i_last;
        o_push.a       = preview ? res_prev : res_sum;
        o_push.b       = res_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= C_PREVIEW_MAX;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_index <= '0;
            r_dmac  <= '0;
            r_smac  <= '0;
            r_etype <= '0;
            r_ihl   <= '0;
            r_tlen  <= '0;
            r_proto <= '0;
            r_sip   <= '0;
            r_dip   <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_toff  <= '0;
        end else if (i_accept) begin
            r_index <= n_index;
            r_dmac  <= n_dmac;
            r_smac  <= n_smac;
            r_etype <= n_etype;
            r_ihl   <= n_ihl;
            r_tlen  <= n_tlen;
            r_proto <= n_proto;
            r_sip   <= n_sip;
            r_dip   <= n_dip;
            r_sport <= n_sport;
            r_dport <= n_dport;
            r_toff  <= n_toff;
        end
    end

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_index == 16'd0 && r_ihl == 4'd0 && r_toff == 4'd0))
        else $error("frame state not cleared after last byte");

    a_preview_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        preview |-> (hdr_match && plen > 17'sd0 && r_index >= body_at))
        else $error("preview issued outside an IPv4/TCP payload");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |-> (!o_push.a_valid && !o_push.b_valid))
        else $error("result raised without an accepted byte");

endmodule

### rtl/core/ethp_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle
// while i_ready is high. Depends on ethp_pkg.
module ethp_fifo #(
    parameter int unsigned P_DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ethp_pkg::t_ethp_push     i_push,
    output logic                     o_room,
    output logic                     o_valid,
    input  logic                     i_ready,
    output ethp_pkg::t_ethp_result   o_data
);
    import ethp_pkg::*;

    localparam int unsigned PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] C_LAST_PTR = PW'(P_DEPTH - 1);

    t_ethp_result  r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr, wr_ptr1;
    logic [CW-1:0] r_count, n_count, push_n;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == C_LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        pop      = o_valid && i_ready;
        wr_ptr1  = ptr_inc(r_wr_ptr);
        push_n   = CW'(i_push.a_valid) + CW'(i_push.b_valid);
        n_wr_ptr = i_push.b_valid ? ptr_inc(wr_ptr1) :
                   i_push.a_valid ? wr_ptr1 : r_wr_ptr;
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + push_n - CW'(pop);
    end

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(P_DEPTH - 2));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[wr_ptr1] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_DEPTH))
        else $error("result queue overflow");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.b_valid |-> i_push.a_valid)
        else $error("second result pushed without first");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push.a_valid && pop) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("queue count lost track of a pop");

endmodule
